// File: src/sed_pkg.sv
// Shared types, constants and helpers for the Sobel edge magnitude block.
// Used by the controller, the datapath, the root unit and the top level.
// No dependencies.
package sed_pkg;

  // Build-time defaults for the largest frame the line stores hold.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Field widths.
  localparam int PIX_W      = 8;   // grey pixel and edge strength
  localparam int CENTRE_W   = 10;  // reported centre row and column
  localparam int CFG_DATA_W = 11;  // frame_width / frame_height registers
  localparam int CFG_ADDR_W = 1;
  localparam int DIM_W      = 13;  // holds any clamped dimension up to 4096
  localparam int GRAD_W     = 11;  // raw Sobel sum, signed
  localparam int GSH_W      = 9;   // Sobel sum after the floor shift, signed
  localparam int SUMSQ_W    = 17;  // gx^2 + gy^2
  localparam int RAD_W      = 18;  // radicand padded to whole bit pairs
  localparam int ROOT_W     = RAD_W / 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_DATA_W-1:0] FRAME_DIM_RST = 11'd1024;
  localparam logic [DIM_W-1:0]      MIN_DIM       = 13'd3;

  // Controller -> datapath commands.
  typedef struct packed {
    logic in_ready;    // idle, input may transfer
    logic accept;      // input transfer this cycle
    logic grad;        // write line stores, shift window, form gx/gy
    logic square;      // form gx^2 + gy^2
    logic root_start;  // launch the square root
    logic out_load;    // load the output register
  } sed_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic in_valid;    // input side offers a pixel
    logic has_result;  // accepted pixel completes a window
    logic root_done;   // root is ready (one-cycle pulse)
    logic out_free;    // output register empty or draining
  } sed_sts_t;

  // Clamp a dimension register to [3, hi].
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] ext;
    ext = DIM_W'(v);
    if (ext < MIN_DIM) begin
      return MIN_DIM;
    end else if (ext > hi) begin
      return hi;
    end
    return ext;
  endfunction

endpackage

// File: src/sed_isqrt.sv
// Iterative integer square root, one result bit per cycle (radix-2 restoring).
// Depends on sed_pkg.
module sed_isqrt
  import sed_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  localparam int STEP_W = $clog2(ROOT_W);
  localparam int REM_W  = ROOT_W + 1;

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] q_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              fits;

  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, q_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      q_r    <= '0;
      step_r <= STEP_W'(ROOT_W - 1);
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      q_r    <= {q_r[ROOT_W-2:0], fits};
      step_r <= step_r - STEP_W'(1);
    end
  end

  assign root = q_r;
  assign done = done_r;

  // Done is a single pulse right after the last step.
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("root done pulse held longer than one cycle");

endmodule

// File: src/sed_dpath.sv
// Datapath: line stores, 3x3 window, raster counters, Sobel sums, squares,
// root unit and the output register. Depends on sed_pkg and sed_isqrt.
module sed_dpath
  import sed_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sed_cmd_t               cmd,
  output sed_sts_t               sts,
  input  logic                   in_tvalid,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] MAXW = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAXH = DIM_W'(MAX_HEIGHT);

  // Configuration and raster position.
  logic [CFG_DATA_W-1:0] width_r, height_r;
  logic [COL_W-1:0]      col_r;
  logic [ROW_W-1:0]      row_r;
  logic [DIM_W-1:0]      w_eff, h_eff, col_ext, row_ext;
  logic                  col_wrap, row_wrap;

  // Item registers.
  logic [PIX_W-1:0]      pix_r, top_rd_r, mid_rd_r;
  logic [COL_W-1:0]      col_item_r;
  logic [ROW_W-1:0]      row_item_r;
  logic                  result_r, last_r;

  logic [PIX_W-1:0]      line_upper [MAX_WIDTH];
  logic [PIX_W-1:0]      line_middle [MAX_WIDTH];
  logic [PIX_W-1:0]      win_r [6];

  logic signed [GRAD_W-1:0] gx_full, gy_full, gx_sh, gy_sh;
  logic signed [GSH_W-1:0]  gx_r, gy_r;
  logic signed [2*GSH_W-1:0] sqx, sqy;
  logic [SUMSQ_W-1:0]       sumsq_r;

  logic [ROOT_W-1:0]     root;
  logic                  root_done;
  logic [PIX_W-1:0]      edge_sat;
  logic [ROW_W-1:0]      row_m1;
  logic [COL_W-1:0]      col_m1;

  logic                  out_valid_r, out_last_r;
  logic [PIX_W-1:0]      out_edge_r;
  logic [CENTRE_W-1:0]   out_row_r, out_col_r;

  assign w_eff    = clamp_dim(width_r, MAXW);
  assign h_eff    = clamp_dim(height_r, MAXH);
  assign col_ext  = DIM_W'(col_r);
  assign row_ext  = DIM_W'(row_r);
  assign col_wrap = (col_ext + DIM_W'(1)) >= w_eff;
  assign row_wrap = (row_ext + DIM_W'(1)) >= h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_DIM_RST;
      height_r <= FRAME_DIM_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: height_r <= cfg_wdata;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      if (col_wrap) begin
        col_r <= '0;
        row_r <= row_wrap ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r      <= in_tdata[PIX_W-1:0];
      col_item_r <= col_r;
      row_item_r <= row_r;
      result_r   <= (row_ext >= DIM_W'(2)) && (col_ext >= DIM_W'(2));
      last_r     <= (row_ext == h_eff - DIM_W'(1)) && (col_ext == w_eff - DIM_W'(1));
    end
  end

  // Line stores: read on accept, write back during the gradient step.
  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      line_upper[col_item_r] <= mid_rd_r;
    end
    if (cmd.accept) begin
      top_rd_r <= line_upper[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      line_middle[col_item_r] <= pix_r;
    end
    if (cmd.accept) begin
      mid_rd_r <= line_middle[col_r];
    end
  end

  // Window: entries 0..2 are the left column (top..bottom), 3..5 the middle.
  always_comb begin
    gx_full = ($signed({3'b0, win_r[0]}) - $signed({3'b0, top_rd_r}))
            + (($signed({3'b0, win_r[1]}) - $signed({3'b0, mid_rd_r})) <<< 1)
            + ($signed({3'b0, win_r[2]}) - $signed({3'b0, pix_r}));
    gy_full = ($signed({3'b0, win_r[2]}) + ($signed({3'b0, win_r[5]}) <<< 1)
               + $signed({3'b0, pix_r}))
            - ($signed({3'b0, win_r[0]}) + ($signed({3'b0, win_r[3]}) <<< 1)
               + $signed({3'b0, top_rd_r}));
    gx_sh = gx_full >>> 2;
    gy_sh = gy_full >>> 2;
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_rd_r;
      win_r[4] <= mid_rd_r;
      win_r[5] <= pix_r;
      gx_r     <= gx_sh[GSH_W-1:0];
      gy_r     <= gy_sh[GSH_W-1:0];
    end
  end

  assign sqx = gx_r * gx_r;
  assign sqy = gy_r * gy_r;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sumsq_r <= SUMSQ_W'({1'b0, sqx[2*PIX_W-1:0]}) + SUMSQ_W'({1'b0, sqy[2*PIX_W-1:0]});
    end
  end

  sed_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .radicand (RAD_W'(sumsq_r)),
    .root     (root),
    .done     (root_done)
  );

  assign edge_sat = root[ROOT_W-1] ? {PIX_W{1'b1}} : root[PIX_W-1:0];
  assign row_m1   = row_item_r - ROW_W'(1);
  assign col_m1   = col_item_r - COL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_edge_r <= edge_sat;
      out_row_r  <= CENTRE_W'(row_m1);
      out_col_r  <= CENTRE_W'(col_m1);
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_col_r, out_row_r, out_edge_r});
  assign out_tlast  = out_last_r;

  assign sts.in_valid   = in_tvalid;
  assign sts.has_result = result_r;
  assign sts.root_done  = root_done;
  assign sts.out_free   = !out_valid_r || out_tready;

  logic [2*ROOT_W+1:0] root_sq, root1_sq;
  assign root_sq  = (2*ROOT_W+2)'(root) * (2*ROOT_W+2)'(root);
  assign root1_sq = ((2*ROOT_W+2)'(root) + (2*ROOT_W+2)'(1))
                  * ((2*ROOT_W+2)'(root) + (2*ROOT_W+2)'(1));

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    col_ext < w_eff)
    else $error("column counter beyond frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    row_ext < h_eff)
    else $error("row counter beyond frame height");

  a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (root_sq <= (2*ROOT_W+2)'(sumsq_r)) &&
                  (root1_sq > (2*ROOT_W+2)'(sumsq_r)))
    else $error("square root result not the floor root of gx^2 + gy^2");

endmodule

// File: src/sed_ctrl.sv
// Controller state machine: sequences accept, gradient, square, root and
// output load for one pixel at a time. Depends on sed_pkg.
module sed_ctrl
  import sed_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  sed_sts_t sts,
  output sed_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GRAD   = 3'd1;
  localparam logic [2:0] S_SQUARE = 3'd2;
  localparam logic [2:0] S_START  = 3'd3;
  localparam logic [2:0] S_ROOT   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.accept   = sts.in_valid;
        if (sts.in_valid) begin
          state_nxt = S_GRAD;
        end
      end
      S_GRAD: begin
        cmd.grad  = 1'b1;
        state_nxt = sts.has_result ? S_SQUARE : S_IDLE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_START;
      end
      S_START: begin
        cmd.root_start = 1'b1;
        state_nxt      = S_ROOT;
      end
      S_ROOT: begin
        if (sts.root_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_to_grad: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_GRAD))
    else $error("accepted pixel not followed by gradient step");

  a_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
    sts.root_done |-> (state_r == S_ROOT))
    else $error("root finished outside the root wait state");

endmodule

// File: src/sobel_edge_magnitude.sv
// Sobel 3x3 edge magnitude over a raster stream of 8-bit grey pixels.
// Top level: ties the controller (sed_ctrl) to the datapath (sed_dpath).
// Depends on sed_pkg, sed_ctrl, sed_dpath, sed_isqrt.
//
// Pixels arrive in raster order on the in_ channel. Two line stores hold the
// two rows above and a six-entry register window holds the two columns to
// the left, so every pixel at row >= 2 and column >= 2 closes a 3x3 window
// and yields one result transfer on the out_ channel: floor(sqrt(gx^2+gy^2))
// saturated to 255, where gx and gy are the Sobel sums each floored by a
// right shift of two. The result carries the window's centre row and column
// and raises out_tlast on the frame's last result; border pixels give no
// result. Frame size comes from frame_width (index 0) and frame_height
// (index 1), clamped to [3, MAX_WIDTH] and [3, MAX_HEIGHT]; any write to
// either restarts the frame at row 0, column 0. Write them only while the
// block is idle. One pixel is handled at a time. A border pixel passes
// through the accept step and the gradient step (line store read-back and
// update); a pixel that closes a window passes through the accept,
// gradient, square and launch steps, the square-root unit (one of its nine
// root bits per cycle) until its done pulse is seen, and the output-load
// step. The output-load step waits for as long as the previous result still
// sits unaccepted in the output register. The output register lets the next
// pixel be taken while a result still waits for out_tready.
module sobel_edge_magnitude
  import sed_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Pixel input
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] gray_pixel
  // Result output
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] edge_strength, [17:8] centre_row,
                                             // [27:18] centre_col, [31:28] zero
  output logic                   out_tlast,  // frame_last
  // Configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  sed_cmd_t cmd;
  sed_sts_t sts;

  // Sequence one pixel at a time.
  sed_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Storage, arithmetic and the output register.
  sed_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Take a pixel only while the controller sits idle.
  assign in_tready = cmd.in_ready;

endmodule
